// ----- src/fnvb_pkg.sv -----
// Shared constants, types and helper functions for the FNV-1a bucket index block.
package fnvb_pkg;

    localparam int HASH_W      = 64;
    localparam int BYTE_W      = 8;
    localparam int COUNT_W     = 17;
    localparam int IDX_W       = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [HASH_W-1:0]  FNV_BASIS    = 64'hCBF2_9CE4_8422_2325;
    localparam logic [COUNT_W-1:0] COUNT_RESET  = 17'd256;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = 17'd65536;
    localparam logic [COUNT_W-1:0] COUNT_MIN    = 17'd1;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    // One FNV-1a round. The prime is 2^40 + 0x1B3, so the product is a few shifted adds.
    function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
                                                   input logic [BYTE_W-1:0] b);
        logic [HASH_W-1:0] x;
        x = h ^ {{(HASH_W-BYTE_W){1'b0}}, b};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

    // Zero counts act as one bucket and counts above the maximum act as the maximum.
    function automatic logic [COUNT_W-1:0] eff_count(input logic [COUNT_W-1:0] c);
        logic [COUNT_W-1:0] r;
        if (c == '0) begin
            r = COUNT_MIN;
        end else if (c > COUNT_MAX) begin
            r = COUNT_MAX;
        end else begin
            r = c;
        end
        return r;
    endfunction

endpackage

// ----- src/fnvb_front.sv -----
// Byte front end: runs the FNV-1a hash and queues the final hash when a key ends.
module fnvb_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [fnvb_pkg::BYTE_W-1:0] i_key_byte,
    input  logic                        i_queue_full,
    output logic                        o_ready,
    output logic                        o_push,
    output logic [fnvb_pkg::HASH_W-1:0] o_push_hash
);
    import fnvb_pkg::*;

    logic [HASH_W-1:0] r_hash;
    logic [HASH_W-1:0] n_hash;
    logic              w_accept;
    logic              w_end_key;

    assign o_ready     = !i_queue_full;
    assign w_accept    = i_valid && o_ready;
    assign w_end_key   = (i_key_byte == '0);
    assign o_push      = w_accept && w_end_key;
    assign o_push_hash = r_hash;

    always_comb begin
        n_hash = r_hash;
        if (w_accept) begin
            if (w_end_key) begin
                n_hash = FNV_BASIS;
            end else begin
                n_hash = fnv_step(r_hash, i_key_byte);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= FNV_BASIS;
        end else begin
            r_hash <= n_hash;
        end
    end

endmodule

// ----- src/fnvb_queue.sv -----
// Short queue of finished hashes between the byte front end and the modulo unit.
module fnvb_queue #(
    parameter int DEPTH = fnvb_pkg::QUEUE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic [fnvb_pkg::HASH_W-1:0]   i_push_hash,
    input  logic                          i_pop,
    output logic [fnvb_pkg::HASH_W-1:0]   o_head_hash,
    output fnvb_pkg::t_queue_status       o_status
);
    import fnvb_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [HASH_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              w_push;
    logic              w_pop;

    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign w_push         = i_push && !o_status.full;
    assign w_pop          = i_pop && !o_status.empty;
    assign o_head_hash    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_hash;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- src/fnvb_mod.sv -----
// Back end: bit-serial hash modulo bucket count and the registered result stage.
module fnvb_mod (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [fnvb_pkg::COUNT_W-1:0] i_bucket_count,
    input  fnvb_pkg::t_queue_status      i_queue_status,
    input  logic [fnvb_pkg::HASH_W-1:0]  i_head_hash,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [fnvb_pkg::HASH_W-1:0]  o_hash_value,
    output logic [fnvb_pkg::IDX_W-1:0]   o_bucket_index
);
    import fnvb_pkg::*;

    localparam int STEP_W = $clog2(HASH_W);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state             r_state;
    t_state             n_state;
    logic [HASH_W-1:0]  r_hash;
    logic [HASH_W-1:0]  r_shift;
    logic [IDX_W-1:0]   r_rem;
    logic [COUNT_W-1:0] r_div;
    logic [STEP_W-1:0]  r_step;
    logic               r_out_valid;
    logic [HASH_W-1:0]  r_out_hash;
    logic [IDX_W-1:0]   r_out_idx;
    logic [COUNT_W-1:0] w_trial;
    logic [IDX_W-1:0]   w_rem_next;
    logic               w_out_free;

    assign w_trial    = {r_rem, r_shift[HASH_W-1]};
    assign w_rem_next = (w_trial >= r_div) ? IDX_W'(w_trial - r_div) : w_trial[IDX_W-1:0];
    assign w_out_free = !r_out_valid || i_ready;
    assign o_pop      = (r_state == S_IDLE) && !i_queue_status.empty;

    assign o_valid        = r_out_valid;
    assign o_hash_value   = r_out_hash;
    assign o_bucket_index = r_out_idx;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (!i_queue_status.empty) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_step == STEP_W'(HASH_W - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_hash  <= i_head_hash;
            r_shift <= i_head_hash;
            r_rem   <= '0;
            r_step  <= '0;
            r_div   <= eff_count(i_bucket_count);
        end else if (r_state == S_DIV) begin
            r_shift <= r_shift << 1;
            r_rem   <= w_rem_next;
            r_step  <= r_step + 1'b1;
        end
        if (r_state == S_DONE && w_out_free) begin
            r_out_hash <= r_hash;
            r_out_idx  <= r_rem;
        end
    end

endmodule

// ----- src/fnvb_top.sv -----
// Top level of the FNV-1a bucket index block: config register, front end, queue and modulo unit.
//
// Key bytes are taken at one per cycle; each byte folds into a registered 64-bit FNV-1a hash.
// A zero byte ends the key, puts the finished hash in a QUEUE_DEPTH-entry queue and
// restarts the hash at the offset basis, so the next key can stream in at once. The modulo unit
// behind the queue works one hash bit per cycle: it loads a hash, runs restoring division over
// its 64 bits and hands the result to the output register once it is free, then takes the next hash.
// Byte input stalls whenever the queue is full. A bucket count of zero acts as one bucket and
// counts above 65536 act as 65536; the count is sampled when a hash enters the modulo unit.
module fnv1a_bucket_index_core #(
    parameter int QUEUE_DEPTH = fnvb_pkg::QUEUE_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [fnvb_pkg::COUNT_W-1:0] i_cfg_wdata,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [fnvb_pkg::BYTE_W-1:0]  i_key_byte,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [fnvb_pkg::HASH_W-1:0]  o_hash_value,
    output logic [fnvb_pkg::IDX_W-1:0]   o_bucket_index
);
    import fnvb_pkg::*;

    logic [COUNT_W-1:0] r_bucket_count;
    logic               w_push;
    logic [HASH_W-1:0]  w_push_hash;
    logic               w_pop;
    logic [HASH_W-1:0]  w_head_hash;
    t_queue_status      w_queue_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_count <= COUNT_RESET;
        end else if (i_cfg_we) begin
            r_bucket_count <= i_cfg_wdata;
        end
    end

    fnvb_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_key_byte   (i_key_byte),
        .i_queue_full (w_queue_status.full),
        .o_ready      (o_ready),
        .o_push       (w_push),
        .o_push_hash  (w_push_hash)
    );

    fnvb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_hash (w_push_hash),
        .i_pop       (w_pop),
        .o_head_hash (w_head_hash),
        .o_status    (w_queue_status)
    );

    fnvb_mod u_mod (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_bucket_count (r_bucket_count),
        .i_queue_status (w_queue_status),
        .i_head_hash    (w_head_hash),
        .o_pop          (w_pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_hash_value   (o_hash_value),
        .o_bucket_index (o_bucket_index)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_queue_status.full)
        else $error("Hash pushed into a full queue.");

    a_end_of_key_pushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && (i_key_byte == '0)) |-> w_push)
        else $error("Terminating byte transfer did not queue a hash.");

    a_data_byte_no_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && (i_key_byte != '0)) |-> !w_push)
        else $error("Nonzero key byte queued a hash.");

    a_pop_only_when_filled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_queue_status.empty)
        else $error("Modulo unit took a hash from an empty queue.");

endmodule
